FILE: rtl/homography_overlap_test_top_defines.svh
// Assertion macros for the homography overlap test block.
`ifndef HOMOGRAPHY_OVERLAP_TEST_TOP_DEFINES_SVH
`define HOMOGRAPHY_OVERLAP_TEST_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HOT_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HOT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hot_pkg.sv
// Shared types and constants for the homography overlap test block.
package hot_pkg;

    // Field formats
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned COEF_W     = 40;
    localparam int unsigned PERSP_W    = 32;
    localparam int unsigned THR_W      = 32;
    localparam int unsigned COEF_FRAC  = 24;
    localparam int unsigned COORD_FRAC = 4;
    localparam int unsigned PERSP_FRAC = 31;
    localparam int unsigned PROJ_FRAC  = 8;

    // Extra quotient bits after the integer divide
    localparam int unsigned QSTEPS = PERSP_FRAC + PROJ_FRAC - COEF_FRAC;

    // Quotient saturates at 2^Q_BITS; anything that large always misses
    localparam int unsigned Q_BITS    = 24;
    localparam int unsigned NUM_CELLS = Q_BITS + 1;

    // Datapath widths
    localparam int unsigned PROD_W  = COEF_W + COORD_W + 1;
    localparam int unsigned SUM_W   = PROD_W + 1;
    localparam int unsigned PPROD_W = PERSP_W + COORD_W + 1;
    localparam int unsigned W_W     = PPROD_W + 2;
    localparam int unsigned DIV_W   = W_W + NUM_CELLS;
    localparam int unsigned DIFF_W  = Q_BITS + 3;
    localparam int unsigned MAG_D_W = 22;
    localparam int unsigned SQ_W    = 2 * MAG_D_W;
    localparam int unsigned LIM_SH  = 2 * PROJ_FRAC - 8;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX           = 4'd0,
        REG_COEF_XY           = 4'd1,
        REG_COEF_XT           = 4'd2,
        REG_COEF_YX           = 4'd3,
        REG_COEF_YY           = 4'd4,
        REG_COEF_YT           = 4'd5,
        REG_PERSPECTIVE_PAIR  = 4'd6,
        REG_THRESHOLD_SQUARED = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
    } in_item_t;

    typedef struct packed {
        logic overlapping;
        logic degenerate;
    } out_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]  xx;
        logic signed [COEF_W-1:0]  xy;
        logic signed [COEF_W-1:0]  xt;
        logic signed [COEF_W-1:0]  yx;
        logic signed [COEF_W-1:0]  yy;
        logic signed [COEF_W-1:0]  yt;
        logic signed [PERSP_W-1:0] h20;
        logic signed [PERSP_W-1:0] h21;
    } coef_set_t;

    // Request travelling down the divider chain
    typedef struct packed {
        logic [DIV_W-1:0]     rem_u;
        logic [DIV_W-1:0]     rem_v;
        logic [W_W-1:0]       den;
        logic [NUM_CELLS-1:0] qu;
        logic [NUM_CELLS-1:0] qv;
        logic                 neg_u;
        logic                 neg_v;
        logic                 deg;
        logic [COORD_W-1:0]   sx;
        logic [COORD_W-1:0]   sy;
    } div_item_t;

endpackage

FILE: rtl/hot_front.sv
// Front end: products, homogeneous sums, magnitudes and divider setup.
module hot_front
    import hot_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  in_item_t  up_item,
    input  coef_set_t coefs,
    input  logic      dn_ready,
    output logic      up_ready,
    output logic      dn_valid,
    output div_item_t dn_item
);

    logic signed [PROD_W-1:0]  pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    logic signed [PPROD_W-1:0] p20_reg, p21_reg;
    logic [COORD_W-1:0]        sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic signed [SUM_W-1:0]   nu_reg, nv_reg;
    logic signed [W_W-1:0]     w_reg;
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      ready1, ready2, ready3;
    logic signed [COORD_W:0]   x_s, y_s;
    logic [SUM_W-1:0]          mag_u, mag_v;
    div_item_t                 item3_reg, item3_next;

    assign ready3   = !v3_reg || dn_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign up_ready = ready1;
    assign dn_valid = v3_reg;
    assign dn_item  = item3_reg;

    assign x_s = $signed({1'b0, up_item.first_x});
    assign y_s = $signed({1'b0, up_item.first_y});

    // Stage 3 setup: signs, magnitudes, scaled dividends
    always_comb
    begin
        mag_u = nu_reg[SUM_W-1] ? SUM_W'(-nu_reg) : SUM_W'(nu_reg);
        mag_v = nv_reg[SUM_W-1] ? SUM_W'(-nv_reg) : SUM_W'(nv_reg);
        item3_next.rem_u = DIV_W'(mag_u) << QSTEPS;
        item3_next.rem_v = DIV_W'(mag_v) << QSTEPS;
        item3_next.den   = w_reg[W_W-1] ? W_W'(-w_reg) : W_W'(w_reg);
        item3_next.qu    = '0;
        item3_next.qv    = '0;
        item3_next.neg_u = nu_reg[SUM_W-1] ^ w_reg[W_W-1];
        item3_next.neg_v = nv_reg[SUM_W-1] ^ w_reg[W_W-1];
        item3_next.deg   = (w_reg == '0);
        item3_next.sx    = sx2_reg;
        item3_next.sy    = sy2_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1) v1_reg <= up_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (ready1 && up_valid)
        begin
            pxx_reg <= coefs.xx * x_s;
            pxy_reg <= coefs.xy * y_s;
            pyx_reg <= coefs.yx * x_s;
            pyy_reg <= coefs.yy * y_s;
            p20_reg <= coefs.h20 * x_s;
            p21_reg <= coefs.h21 * y_s;
            sx1_reg <= up_item.second_x;
            sy1_reg <= up_item.second_y;
        end
        if (ready2 && v1_reg)
        begin
            nu_reg  <= SUM_W'(pxx_reg) + SUM_W'(pxy_reg)
                       + (SUM_W'(coefs.xt) <<< COORD_FRAC);
            nv_reg  <= SUM_W'(pyx_reg) + SUM_W'(pyy_reg)
                       + (SUM_W'(coefs.yt) <<< COORD_FRAC);
            w_reg   <= W_W'(p20_reg) + W_W'(p21_reg)
                       + $signed(W_W'(64'd1 << (PERSP_FRAC + COORD_FRAC)));
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
        end
        if (ready3 && v2_reg)
            item3_reg <= item3_next;
    end

endmodule

FILE: rtl/hot_cell.sv
// One divider cell: decides one quotient bit for both coordinates.
module hot_cell
    import hot_pkg::*;
#(
    parameter int unsigned SHIFT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  div_item_t up_item,
    input  logic      dn_ready,
    output logic      up_ready,
    output logic      dn_valid,
    output div_item_t dn_item
);

    logic             valid_reg;
    div_item_t        item_reg, item_next;
    logic [DIV_W-1:0] dsh;
    logic             bit_u, bit_v;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    // Restoring step against the shifted divisor
    always_comb
    begin
        dsh   = DIV_W'(up_item.den) << SHIFT;
        bit_u = (up_item.rem_u >= dsh);
        bit_v = (up_item.rem_v >= dsh);
        item_next       = up_item;
        item_next.rem_u = bit_u ? up_item.rem_u - dsh : up_item.rem_u;
        item_next.rem_v = bit_v ? up_item.rem_v - dsh : up_item.rem_v;
        item_next.qu    = {up_item.qu[NUM_CELLS-2:0], bit_u};
        item_next.qv    = {up_item.qv[NUM_CELLS-2:0], bit_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

endmodule

FILE: rtl/hot_back.sv
// Back end: projected point, clamped differences, squared distance test.
module hot_back
    import hot_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    input  div_item_t        up_item,
    input  logic [THR_W-1:0] thr,
    input  logic             dn_ready,
    output logic             up_ready,
    output logic             dn_valid,
    output out_item_t        dn_item
);

    logic [MAG_D_W-1:0] ax_reg, ay_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic               deg1_reg, deg2_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic               ready1, ready2, ready3;
    out_item_t          out_reg, out_next;
    logic [SQ_W:0]      dist2, limit;

    // |second - projected|, clamped; large quotients saturate first
    function automatic logic [MAG_D_W-1:0] diff_mag(
        input logic [NUM_CELLS-1:0] q,
        input logic                 neg,
        input logic [COORD_W-1:0]   s
    );
        logic [NUM_CELLS-1:0]     qv;
        logic signed [DIFF_W-1:0] proj;
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        mag;
        qv   = q[Q_BITS] ? NUM_CELLS'(1) << Q_BITS : {1'b0, q[Q_BITS-1:0]};
        proj = neg ? -$signed(DIFF_W'(qv)) : $signed(DIFF_W'(qv));
        diff = $signed(DIFF_W'({s, {(PROJ_FRAC - COORD_FRAC){1'b0}}})) - proj;
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        if (mag > (DIFF_W'(1) << (MAG_D_W - 1)))
            mag = DIFF_W'(1) << (MAG_D_W - 1);
        return mag[MAG_D_W-1:0];
    endfunction

    assign ready3   = !v3_reg || dn_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign up_ready = ready1;
    assign dn_valid = v3_reg;
    assign dn_item  = out_reg;

    // Final compare against the scaled limit
    always_comb
    begin
        dist2 = (SQ_W + 1)'(sqx_reg) + (SQ_W + 1)'(sqy_reg);
        limit = (SQ_W + 1)'(thr) << LIM_SH;
        out_next.degenerate  = deg2_reg;
        out_next.overlapping = !deg2_reg && (dist2 < limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1) v1_reg <= up_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && up_valid)
        begin
            ax_reg   <= diff_mag(up_item.qu, up_item.neg_u, up_item.sx);
            ay_reg   <= diff_mag(up_item.qv, up_item.neg_v, up_item.sy);
            deg1_reg <= up_item.deg;
        end
        if (ready2 && v1_reg)
        begin
            sqx_reg  <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqy_reg  <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            deg2_reg <= deg1_reg;
        end
        if (ready3 && v2_reg)
            out_reg <= out_next;
    end

endmodule

FILE: rtl/homography_overlap_test_top.sv
// Pipeline: 3 front stages, 25 divider cells, 3 back stages; each cell resolves
// one quotient bit. Throughput: one request per cycle while out_stall is low.
// Every stage holds its request under output stall; bubbles still close up.
// Reset clears all valid bits and loads the default homography (identity) and
// a threshold of 1024; there is no clearing pass.
`include "homography_overlap_test_top_defines.svh"
// Top level: configuration registers, front end, divider chain, back end.
module homography_overlap_test_top
    import hot_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    logic signed [COEF_W-1:0]  xx_reg, xy_reg, xt_reg, yx_reg, yy_reg, yt_reg;
    logic [CFG_DATA_W-1:0]     persp_reg;
    logic [THR_W-1:0]          thr_reg;
    coef_set_t                 coefs;
    logic                      front_ready;
    div_item_t                 chain_item  [NUM_CELLS+1];
    logic                      chain_valid [NUM_CELLS+1];
    logic                      chain_ready [NUM_CELLS+1];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_reg    <= COEF_W'(64'd1 << COEF_FRAC);
            xy_reg    <= '0;
            xt_reg    <= '0;
            yx_reg    <= '0;
            yy_reg    <= COEF_W'(64'd1 << COEF_FRAC);
            yt_reg    <= '0;
            persp_reg <= '0;
            thr_reg   <= THR_W'(1024);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_COEF_XX:           xx_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_XY:           xy_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_XT:           xt_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_YX:           yx_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_YY:           yy_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_YT:           yt_reg    <= cfg_data[COEF_W-1:0];
                REG_PERSPECTIVE_PAIR:  persp_reg <= cfg_data;
                REG_THRESHOLD_SQUARED: thr_reg   <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        coefs.xx  = xx_reg;
        coefs.xy  = xy_reg;
        coefs.xt  = xt_reg;
        coefs.yx  = yx_reg;
        coefs.yy  = yy_reg;
        coefs.yt  = yt_reg;
        coefs.h20 = persp_reg[PERSP_W-1:0];
        coefs.h21 = persp_reg[2*PERSP_W-1:PERSP_W];
    end

    assign in_stall = !front_ready;

    hot_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_item  (in_data),
        .coefs    (coefs),
        .dn_ready (chain_ready[0]),
        .up_ready (front_ready),
        .dn_valid (chain_valid[0]),
        .dn_item  (chain_item[0])
    );

    // Divider chain, saturation bit first, then quotient MSB to LSB
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        hot_cell #(
            .SHIFT (Q_BITS - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_item  (chain_item[k]),
            .dn_ready (chain_ready[k+1]),
            .up_ready (chain_ready[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_item  (chain_item[k+1])
        );
    end

    hot_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[NUM_CELLS]),
        .up_item  (chain_item[NUM_CELLS]),
        .thr      (thr_reg),
        .dn_ready (!out_stall),
        .up_ready (chain_ready[NUM_CELLS]),
        .dn_valid (out_valid),
        .dn_item  (out_data)
    );

    // Checks
    `HOT_CHECK_NOW(a_deg_no_overlap, out_valid && out_data.degenerate,
        !out_data.overlapping, "degenerate result reports overlap")
    `HOT_CHECK_NOW(a_stall_only_full, in_stall, out_valid && out_stall,
        "input stalled without output backpressure")
    `HOT_CHECK_NEXT(a_thr_write, cfg_wen && (cfg_index == REG_THRESHOLD_SQUARED),
        thr_reg == $past(cfg_data[THR_W-1:0]), "threshold write lost")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the homography overlap test block.
`timescale 1ns / 1ps
module testbench;
    import hot_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;
    localparam logic [63:0] QUOT_CAP = 64'd1 << 40;
    localparam logic signed [63:0] DIFF_CAP = 64'sd1 << 21;
    localparam int unsigned DRAIN_CYCLES = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;

    homography_overlap_test_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Register shadow, pending pairs, expected verdicts
    logic [63:0] hom_reg [8];
    in_item_t    pair_queue [$];
    out_item_t   verdict_queue [$];
    int          errors;
    bit          no_idle;
    bit          hold_req;
    bit          hold_done;
    int          pair_gap;
    int          stall_cnt;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] sext40(logic [63:0] v);
        return {{24{v[39]}}, v[39:0]};
    endfunction

    function automatic logic [63:0] sext32(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // Signed n / d in Q.8, restoring steps for the fraction bits, saturating
    function automatic logic signed [63:0] divide_q8(logic [63:0] n, logic [63:0] d);
        logic        nneg;
        logic        dneg;
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] qbit;
        nneg = n[63];
        dneg = d[63];
        nm = nneg ? 64'd0 - n : n;
        dm = dneg ? 64'd0 - d : d;
        q = nm / dm;
        r = nm % dm;
        if (q > QUOT_CAP)
            q = QUOT_CAP;
        for (int i = 0; i < QSTEPS; i++)
        begin
            if (r >= dm - r)
            begin
                r = r - (dm - r);
                qbit = 64'd1;
            end
            else
            begin
                r = r + r;
                qbit = 64'd0;
            end
            q = (q >= QUOT_CAP) ? QUOT_CAP : ((q << 1) | qbit);
        end
        return (nneg != dneg) ? -$signed(q) : $signed(q);
    endfunction

    // Projects (x, y); returns 1 when w is zero
    function automatic logic map_point(input logic [15:0] x, input logic [15:0] y,
                                       output logic signed [63:0] pu,
                                       output logic signed [63:0] pv);
        logic [63:0] xe;
        logic [63:0] ye;
        logic [63:0] nu;
        logic [63:0] nv;
        logic [63:0] w;
        xe = {48'd0, x};
        ye = {48'd0, y};
        nu = sext40(hom_reg[REG_COEF_XX]) * xe + sext40(hom_reg[REG_COEF_XY]) * ye
           + (sext40(hom_reg[REG_COEF_XT]) << COORD_FRAC);
        nv = sext40(hom_reg[REG_COEF_YX]) * xe + sext40(hom_reg[REG_COEF_YY]) * ye
           + (sext40(hom_reg[REG_COEF_YT]) << COORD_FRAC);
        w = sext32(hom_reg[REG_PERSPECTIVE_PAIR][31:0]) * xe
          + sext32(hom_reg[REG_PERSPECTIVE_PAIR][63:32]) * ye
          + (64'd1 << (PERSP_FRAC + COORD_FRAC));
        pu = 64'sd0;
        pv = 64'sd0;
        if (w == 64'd0)
            return 1'b1;
        pu = divide_q8(nu, w);
        pv = divide_q8(nv, w);
        return 1'b0;
    endfunction

    function automatic logic signed [63:0] clamp_diff(logic signed [63:0] d);
        if (d > DIFF_CAP)
            return DIFF_CAP;
        if (d < -DIFF_CAP)
            return -DIFF_CAP;
        return d;
    endfunction

    function automatic out_item_t predict_overlap(in_item_t it);
        out_item_t         res;
        logic signed [63:0] pu;
        logic signed [63:0] pv;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0]        dist2;
        logic [63:0]        limit;
        res.degenerate = map_point(it.first_x, it.first_y, pu, pv);
        res.overlapping = 1'b0;
        if (!res.degenerate)
        begin
            dx = clamp_diff($signed({44'd0, it.second_x, 4'd0}) - pu);
            dy = clamp_diff($signed({44'd0, it.second_y, 4'd0}) - pv);
            dist2 = dx * dx + dy * dy;
            limit = {32'd0, hom_reg[REG_THRESHOLD_SQUARED][31:0]} << LIM_SH;
            res.overlapping = dist2 < limit;
        end
        return res;
    endfunction

    function automatic logic [15:0] near_coord(logic signed [63:0] p);
        logic signed [63:0] c;
        c = (p >>> COORD_FRAC) + $signed(64'($urandom_range(0, 80))) - 64'sd40;
        if (c < 0)
            return 16'd0;
        if (c > 64'sd65535)
            return 16'hffff;
        return c[15:0];
    endfunction

    // Mostly a second point near the projection, sometimes pure noise
    function automatic in_item_t make_pair();
        in_item_t           it;
        logic signed [63:0] pu;
        logic signed [63:0] pv;
        it = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                it.first_x = 16'($urandom_range(0, 4095));
                it.first_y = 16'($urandom_range(0, 4095));
            end
            if (!map_point(it.first_x, it.first_y, pu, pv))
            begin
                it.second_x = near_coord(pu);
                it.second_y = near_coord(pv);
            end
        end
        return it;
    endfunction

    function automatic logic [63:0] pick_coef(bit diag);
        logic signed [63:0] c;
        case ($urandom_range(0, 3))
            0: c = {$urandom(), $urandom()};
            1: c = diag ? 64'sd1 << COEF_FRAC : 64'sd0;
            default:
                c = (diag ? $signed(64'($urandom_range(8388608, 33554432))) : 64'sd0)
                  + $signed(64'($urandom_range(0, 4194304))) - 64'sd2097152;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pick_persp();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return 32'($urandom_range(0, 131072)) - 32'd65536;
    endfunction

    // Drives one register write; caller stands at a rising edge
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PERSPECTIVE_PAIR:  hom_reg[idx] = val;
            REG_THRESHOLD_SQUARED: hom_reg[idx] = {32'd0, val[31:0]};
            REG_COEF_XX, REG_COEF_XY, REG_COEF_XT, REG_COEF_YX, REG_COEF_YY, REG_COEF_YT:
                hom_reg[idx] = {24'd0, val[39:0]};
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_homography(logic [63:0] xx, logic [63:0] xy, logic [63:0] xt,
                                   logic [63:0] yx, logic [63:0] yy, logic [63:0] yt,
                                   logic [63:0] persp, logic [63:0] thr);
        cfg_write(REG_COEF_XX, xx);
        cfg_write(REG_COEF_XY, xy);
        cfg_write(REG_COEF_XT, xt);
        cfg_write(REG_COEF_YX, yx);
        cfg_write(REG_COEF_YY, yy);
        cfg_write(REG_COEF_YT, yt);
        cfg_write(REG_PERSPECTIVE_PAIR, persp);
        cfg_write(REG_THRESHOLD_SQUARED, thr);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every request is in and every verdict is out, then drain
    task automatic wait_idle();
        while (pair_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_pair(int fx, int fy, int sx, int sy);
        in_item_t it;
        it.first_x  = 16'(fx);
        it.first_y  = 16'(fy);
        it.second_x = 16'(sx);
        it.second_y = 16'(sy);
        pair_queue.insert(pair_queue.size(), it);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_pairs
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            pair_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                verdict_queue.insert(verdict_queue.size(), predict_overlap(in_data));
            if (!(in_valid && in_stall))
            begin
                if (pair_gap > 0)
                begin
                    pair_gap <= pair_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pair_queue.size() != 0)
                begin
                    in_data  <= pair_queue.pop_front();
                    in_valid <= 1'b1;
                    pair_gap <= no_idle ? 0 : $urandom_range(0, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin : check_verdicts
        out_item_t want;
        int        n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_cnt <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $error("unexpected result %b", out_data);
                    errors++;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (out_data.overlapping !== want.overlapping)
                    begin
                        $error("overlapping: expected %b, got %b",
                               want.overlapping, out_data.overlapping);
                        errors++;
                    end
                    if (out_data.degenerate !== want.degenerate)
                    begin
                        $error("degenerate: expected %b, got %b",
                               want.degenerate, out_data.degenerate);
                        errors++;
                    end
                end
                n = no_idle ? 0 : $urandom_range(0, 5);
                if (hold_req && !hold_done)
                begin
                    n = 150;
                    hold_done <= 1'b1;
                end
                stall_cnt <= n;
                out_stall <= (n != 0);
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                out_stall <= (stall_cnt > 1);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        errors    = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hom_reg[REG_COEF_XX] = 64'd1 << COEF_FRAC;
        hom_reg[REG_COEF_XY] = 64'd0;
        hom_reg[REG_COEF_XT] = 64'd0;
        hom_reg[REG_COEF_YX] = 64'd0;
        hom_reg[REG_COEF_YY] = 64'd1 << COEF_FRAC;
        hom_reg[REG_COEF_YT] = 64'd0;
        hom_reg[REG_PERSPECTIVE_PAIR] = 64'd0;
        hom_reg[REG_THRESHOLD_SQUARED] = 64'd1024;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset homography: field extremes and the threshold edge (2 px)
        push_pair(0, 0, 0, 0);
        push_pair(65535, 65535, 65535, 65535);
        push_pair(0, 0, 65535, 65535);
        push_pair(65535, 0, 0, 65535);
        push_pair(100, 200, 131, 200);
        push_pair(100, 200, 132, 200);
        push_pair(100, 200, 100, 232);
        push_pair(300, 300, 331, 331);
        wait_idle();

        // w = 0 at x = 1 px when h20 = -1.0, and two spare register indices
        load_homography(64'd1 << COEF_FRAC, 64'd0, 64'd0, 64'd0, 64'd1 << COEF_FRAC, 64'd0,
                        64'h0000_0000_8000_0000, 64'd1024);
        cfg_write(REG_SPARE_LO, 64'hffff_ffff_ffff_ffff);
        cfg_write(REG_SPARE_HI, 64'd0);
        cfg_wen <= 1'b0;
        @(posedge clk);
        push_pair(16, 0, 16, 0);
        push_pair(16, 0, 0, 0);
        push_pair(0, 16, 0, 0);
        push_pair(8, 0, 0, 0);
        wait_idle();

        // Coefficient extremes, all-ones perspective, widest threshold
        load_homography(64'h7f_ffff_ffff, 64'h80_0000_0000, 64'h7f_ffff_ffff,
                        64'h80_0000_0000, 64'h7f_ffff_ffff, 64'h80_0000_0000,
                        64'hffff_ffff_ffff_ffff, 64'hffff_ffff);
        push_pair(0, 0, 0, 0);
        push_pair(65535, 65535, 0, 0);
        push_pair(1, 65535, 65535, 0);
        wait_idle();
        load_homography(64'h80_0000_0000, 64'h7f_ffff_ffff, 64'h80_0000_0000,
                        64'h7f_ffff_ffff, 64'h80_0000_0000, 64'h7f_ffff_ffff,
                        64'h7fff_ffff_7fff_ffff, 64'd0);
        push_pair(0, 0, 0, 0);
        push_pair(65535, 65535, 65535, 65535);
        push_pair(65535, 0, 0, 65535);
        wait_idle();

        // Random homographies; the first long phase gets the receiver hold
        for (int ph = 0; ph < 11; ph++)
        begin
            load_homography(pick_coef(1'b1), pick_coef(1'b0), pick_coef(1'b0) * 200,
                            pick_coef(1'b0), pick_coef(1'b1), pick_coef(1'b0) * 200,
                            {pick_persp(), pick_persp()},
                            ($urandom_range(0, 3) == 0)
                                ? 64'($urandom()) : 64'($urandom_range(0, 4096)));
            no_idle  = (ph % 4 == 1);
            hold_req = (ph == 1);
            for (int k = 0; k < ((ph == 1) ? 100 : 45); k++)
                pair_queue.insert(pair_queue.size(), make_pair());
            wait_idle();
        end

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
